// ----- sv/mahc_pkg.sv -----
// Package for the MPEG audio header check unit: header codes, rate tables,
// reciprocal constants and the payload types of the pipeline stages.
// No dependencies.
`default_nettype none

package mahc_pkg;

   localparam logic [31:0] SYNC_MASK = 32'hFFE0_0000;

   localparam int unsigned KBPS_W      = 9;
   localparam int unsigned COEF_W      = 13;
   localparam int unsigned PROD_FULL_W = KBPS_W + COEF_W;
   localparam int unsigned PROD_W      = 20;
   localparam int unsigned RECIP_W     = 24;
   localparam int unsigned QUOT_FULL_W = PROD_W + RECIP_W;
   localparam int unsigned RECIP_SHIFT = 32;
   localparam int unsigned QUOT_W      = 12;
   localparam int unsigned AVAIL_W     = 16;
   localparam int unsigned LEN_W       = 12;
   localparam int unsigned SUM_W       = QUOT_W + 1;
   localparam int unsigned SCALED_W    = SUM_W + 2;

   typedef enum logic [1:0] {
      VER_25  = 2'd0,
      VER_RSV = 2'd1,
      VER_2   = 2'd2,
      VER_1   = 2'd3
   } version_type;

   typedef enum logic [1:0] {
      LAYER_RSV = 2'd0,
      LAYER_III = 2'd1,
      LAYER_II  = 2'd2,
      LAYER_I   = 2'd3
   } layer_type;

   localparam logic [1:0]  EMPH_RSV  = 2'd2;
   localparam logic [1:0]  FIDX_44K  = 2'd0;
   localparam logic [1:0]  FIDX_48K  = 2'd1;
   localparam logic [1:0]  FIDX_32K  = 2'd2;
   localparam logic [1:0]  FIDX_RSV  = 2'd3;
   localparam logic [3:0]  RIDX_FREE = 4'd0;
   localparam logic [3:0]  RIDX_BAD  = 4'd15;
   localparam logic [AVAIL_W-1:0] MIN_AVAIL = 16'd4;

   // Length coefficients with the bit/s and Hz scale factors folded in; the
   // sample rates are held in units of 100 Hz at the MPEG-1 value.
   localparam logic [COEF_W-1:0] COEF_L1     = 13'd120;
   localparam logic [COEF_W-1:0] COEF_L3_LSF = 13'd720;
   localparam logic [COEF_W-1:0] COEF_STD    = 13'd1440;

   localparam logic [63:0] RECIP_ONE = 64'd1 << RECIP_SHIFT;
   localparam logic [63:0] FREQ_44K  = 64'd441;
   localparam logic [63:0] FREQ_48K  = 64'd480;
   localparam logic [63:0] FREQ_32K  = 64'd320;
   localparam logic [63:0] RECIP_44K_FULL = (RECIP_ONE + FREQ_44K - 64'd1) / FREQ_44K;
   localparam logic [63:0] RECIP_48K_FULL = (RECIP_ONE + FREQ_48K - 64'd1) / FREQ_48K;
   localparam logic [63:0] RECIP_32K_FULL = (RECIP_ONE + FREQ_32K - 64'd1) / FREQ_32K;
   localparam logic [RECIP_W-1:0] RECIP_44K = RECIP_44K_FULL[RECIP_W-1:0];
   localparam logic [RECIP_W-1:0] RECIP_48K = RECIP_48K_FULL[RECIP_W-1:0];
   localparam logic [RECIP_W-1:0] RECIP_32K = RECIP_32K_FULL[RECIP_W-1:0];

   localparam logic [0:15][KBPS_W-1:0] KBPS_M1_L1 = {
      9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
      9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
   localparam logic [0:15][KBPS_W-1:0] KBPS_M1_L2 = {
      9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
   localparam logic [0:15][KBPS_W-1:0] KBPS_M1_L3 = {
      9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
      9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
   localparam logic [0:15][KBPS_W-1:0] KBPS_LSF_L1 = {
      9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
      9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
   localparam logic [0:15][KBPS_W-1:0] KBPS_LSF_L23 = {
      9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
      9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

   function automatic logic [KBPS_W-1:0] kbps_lookup(version_type ver, layer_type layer,
                                                      logic [3:0] ridx);
      logic [KBPS_W-1:0] kbps;
      if (ver == VER_1) begin
         unique case (layer)
            LAYER_I:  kbps = KBPS_M1_L1[ridx];
            LAYER_II: kbps = KBPS_M1_L2[ridx];
            default:  kbps = KBPS_M1_L3[ridx];
         endcase
      end else if (layer == LAYER_I) begin
         kbps = KBPS_LSF_L1[ridx];
      end else begin
         kbps = KBPS_LSF_L23[ridx];
      end
      return kbps;
   endfunction

   function automatic logic [RECIP_W-1:0] recip_lookup(logic [1:0] fidx);
      logic [RECIP_W-1:0] recip;
      unique case (fidx)
         FIDX_44K: recip = RECIP_44K;
         FIDX_48K: recip = RECIP_48K;
         FIDX_32K: recip = RECIP_32K;
         default:  recip = '0;
      endcase
      return recip;
   endfunction

   typedef struct packed {
      logic                ok;
      logic                layer1;
      logic                pad;
      logic [KBPS_W-1:0]   kbps;
      logic [COEF_W-1:0]   coef;
      logic [RECIP_W-1:0]  recip;
      logic [AVAIL_W-1:0]  avail;
   } dec_type;

   typedef struct packed {
      logic                ok;
      logic                layer1;
      logic                pad;
      logic [PROD_W-1:0]   prod;
      logic [RECIP_W-1:0]  recip;
      logic [AVAIL_W-1:0]  avail;
   } prod_type;

   typedef struct packed {
      logic                ok;
      logic                layer1;
      logic                pad;
      logic [QUOT_W-1:0]   quot;
      logic [AVAIL_W-1:0]  avail;
   } quot_type;

endpackage

`default_nettype wire

// ----- sv/mahc_decode.sv -----
// First pipeline stage: checks the header fields and looks up the bitrate,
// the length coefficient and the sample-rate reciprocal. Uses mahc_pkg.
`default_nettype none

module mahc_decode (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   output      logic                         in_ready,
   input  wire logic [31:0]                  header_word,
   input  wire logic [mahc_pkg::AVAIL_W-1:0] bytes_available,
   output      logic                         out_valid,
   input  wire logic                         out_ready,
   output      mahc_pkg::dec_type            out_data
);
   import mahc_pkg::*;

   version_type       ver;
   layer_type         layer;
   logic [3:0]        ridx;
   logic [1:0]        fidx;
   logic [1:0]        emph;
   logic [COEF_W-1:0] base;
   dec_type           data_in;
   dec_type           data_ff;
   logic              valid_ff;

   always_comb begin
      ver   = version_type'(header_word[20:19]);
      layer = layer_type'(header_word[18:17]);
      ridx  = header_word[15:12];
      fidx  = header_word[11:10];
      emph  = header_word[1:0];

      if (layer == LAYER_I) begin
         base = COEF_L1;
      end else if (layer == LAYER_III && ver != VER_1) begin
         base = COEF_L3_LSF;
      end else begin
         base = COEF_STD;
      end

      data_in.ok = ((header_word & SYNC_MASK) == SYNC_MASK) && (ver != VER_RSV) &&
                   (layer != LAYER_RSV) && (ridx != RIDX_FREE) && (ridx != RIDX_BAD) &&
                   (fidx != FIDX_RSV) && (emph != EMPH_RSV) &&
                   (bytes_available >= MIN_AVAIL);
      data_in.layer1 = (layer == LAYER_I);
      data_in.pad    = header_word[9];
      data_in.kbps   = kbps_lookup(ver, layer, ridx);
      unique case (ver)
         VER_1:   data_in.coef = base;
         VER_2:   data_in.coef = base << 1;
         default: data_in.coef = base << 2;
      endcase
      data_in.recip = recip_lookup(fidx);
      data_in.avail = bytes_available;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/mahc_mult.sv -----
// Second and third pipeline stages: forms the scaled bitrate product and
// divides it by the sample rate through a reciprocal multiply. Uses mahc_pkg.
`default_nettype none

module mahc_mult (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output      logic              in_ready,
   input  wire mahc_pkg::dec_type in_data,
   output      logic              out_valid,
   input  wire logic              out_ready,
   output      mahc_pkg::quot_type out_data
);
   import mahc_pkg::*;

   logic [PROD_FULL_W-1:0] prod_full;
   logic [QUOT_FULL_W-1:0] quot_full;
   prod_type               prod_in;
   prod_type               prod_ff;
   logic                   prod_valid_ff;
   quot_type               quot_in;
   quot_type               quot_ff;
   logic                   quot_valid_ff;
   logic                   quot_ready;

   always_comb begin
      prod_full      = PROD_FULL_W'(in_data.kbps) * PROD_FULL_W'(in_data.coef);
      prod_in.ok     = in_data.ok;
      prod_in.layer1 = in_data.layer1;
      prod_in.pad    = in_data.pad;
      prod_in.prod   = prod_full[PROD_W-1:0];
      prod_in.recip  = in_data.recip;
      prod_in.avail  = in_data.avail;

      quot_full      = QUOT_FULL_W'(prod_ff.prod) * QUOT_FULL_W'(prod_ff.recip);
      quot_in.ok     = prod_ff.ok;
      quot_in.layer1 = prod_ff.layer1;
      quot_in.pad    = prod_ff.pad;
      quot_in.quot   = quot_full[RECIP_SHIFT +: QUOT_W];
      quot_in.avail  = prod_ff.avail;
   end

   assign quot_ready = !quot_valid_ff || out_ready;
   assign in_ready   = !prod_valid_ff || quot_ready;
   assign out_valid  = quot_valid_ff;
   assign out_data   = quot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         quot_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            prod_valid_ff <= in_valid;
         end
         if (quot_ready) begin
            quot_valid_ff <= prod_valid_ff;
         end
      end
      if (in_ready && in_valid) begin
         prod_ff <= prod_in;
      end
      if (quot_ready && prod_valid_ff) begin
         quot_ff <= quot_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/mpeg_audio_header_check_unit.sv -----
// MPEG audio frame header check. An accepted item passes through the four-stage
// pipeline of decode, product, reciprocal multiply and compare to the rsp_ ports;
// throughput is one item per cycle while rsp_stall is low.
// Reset, synchronous and active high, empties the pipeline; no other state.
// Uses mahc_pkg, mahc_decode and mahc_mult.
`default_nettype none

module mpeg_audio_header_check_unit (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output      logic                         req_stall,
   input  wire logic [31:0]                  req_header_word,
   input  wire logic [mahc_pkg::AVAIL_W-1:0] req_bytes_available,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_stall,
   output      logic                         rsp_accepted,
   output      logic [mahc_pkg::LEN_W-1:0]   rsp_frame_length
);
   import mahc_pkg::*;

   logic              dec_ready;
   logic              dec_valid;
   dec_type           dec_data;
   logic              mult_ready;
   logic              mult_valid;
   quot_type          mult_data;
   logic              out_ready;
   logic [SUM_W-1:0]  sum;
   logic [SCALED_W-1:0] len;
   logic              accepted_in;
   logic [LEN_W-1:0]  frame_length_in;
   logic              rsp_valid_ff;
   logic              rsp_accepted_ff;
   logic [LEN_W-1:0]  rsp_frame_length_ff;

   mahc_decode u_decode (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req_valid),
      .in_ready        (dec_ready),
      .header_word     (req_header_word),
      .bytes_available (req_bytes_available),
      .out_valid       (dec_valid),
      .out_ready       (mult_ready),
      .out_data        (dec_data)
   );

   mahc_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (mult_ready),
      .in_data   (dec_data),
      .out_valid (mult_valid),
      .out_ready (out_ready),
      .out_data  (mult_data)
   );

   always_comb begin
      sum = SUM_W'(mult_data.quot) + SUM_W'(mult_data.pad);
      if (mult_data.layer1) begin
         len = SCALED_W'(sum) << 2;
      end else begin
         len = SCALED_W'(sum);
      end
      accepted_in     = mult_data.ok && (AVAIL_W'(len) <= mult_data.avail);
      frame_length_in = accepted_in ? len[LEN_W-1:0] : '0;
   end

   assign out_ready        = !rsp_valid_ff || !rsp_stall;
   assign req_stall        = !dec_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = rsp_accepted_ff;
   assign rsp_frame_length = rsp_frame_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= mult_valid;
      end
      if (out_ready && mult_valid) begin
         rsp_accepted_ff     <= accepted_in;
         rsp_frame_length_ff <= frame_length_in;
      end
   end

endmodule

`default_nettype wire
